FILE: hdl/point_segment_distance_sq_macros.svh
// Assertion macros for the point to segment distance block.
// Included by the top level; empty bodies under SYNTHESIS.
`ifndef POINT_SEGMENT_DISTANCE_SQ_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_SQ_MACROS_SVH
`ifndef SYNTHESIS
`define PSD_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define PSD_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define PSD_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define PSD_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

FILE: hdl/psd_pkg.sv
// Types and constants for the point to segment distance block.
// No dependencies.
package psd_pkg;
	localparam int CW = 24;
	localparam int FB = 16;
	localparam int DW = 50;
	localparam int PW = 2 * CW + 2;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	localparam logic [1:0] SEL_START = 2'd0;
	localparam logic [1:0] SEL_END   = 2'd1;
	localparam logic [1:0] SEL_FRAC  = 2'd2;

	typedef struct packed {
		logic signed [CW-1:0] query_x;
		logic signed [CW-1:0] query_y;
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [CW-1:0] end_x;
		logic signed [CW-1:0] end_y;
	} in_item_t;

	typedef struct packed {
		logic [DW-1:0]        dist_sq;
		logic signed [CW-1:0] proj_x;
		logic signed [CW-1:0] proj_y;
	} out_item_t;

	typedef struct packed {
		logic [1:0]           sel;
		logic [PW-1:0]        num;
		logic [PW-1:0]        den;
		logic signed [CW-1:0] qx;
		logic signed [CW-1:0] qy;
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [CW:0]   dx;
		logic signed [CW:0]   dy;
	} job_t;

	typedef struct packed {
		logic valid;
		logic stall;
	} pipe_ctl_t;
endpackage

FILE: hdl/psd_front.sv
// Front end: computes direction, squared length and dot product, classifies the item.
// Depends on psd_pkg.
module psd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  psd_pkg::in_item_t   in_item,
	input  logic                stall,
	output logic                job_valid,
	output psd_pkg::job_t       job
);
	logic signed [psd_pkg::CW:0] dx, dy, wx, wy;
	logic signed [2*psd_pkg::CW+1:0] pxx, pyy, pwx, pwy;
	logic signed [psd_pkg::PW-1:0] l2_s1, dd_s1;
	logic v1_s1;
	psd_pkg::in_item_t it_s1;
	logic signed [psd_pkg::CW:0] dx_s1, dy_s1;

	always_comb begin
		dx  = {in_item.end_x[psd_pkg::CW-1], in_item.end_x}
		    - {in_item.start_x[psd_pkg::CW-1], in_item.start_x};
		dy  = {in_item.end_y[psd_pkg::CW-1], in_item.end_y}
		    - {in_item.start_y[psd_pkg::CW-1], in_item.start_y};
		wx  = {in_item.query_x[psd_pkg::CW-1], in_item.query_x}
		    - {in_item.start_x[psd_pkg::CW-1], in_item.start_x};
		wy  = {in_item.query_y[psd_pkg::CW-1], in_item.query_y}
		    - {in_item.start_y[psd_pkg::CW-1], in_item.start_y};
		pxx = dx * dx;
		pyy = dy * dy;
		pwx = wx * dx;
		pwy = wy * dy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (!stall) begin
			v1_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			l2_s1 <= (psd_pkg::PW)'(pxx) + (psd_pkg::PW)'(pyy);
			dd_s1 <= (psd_pkg::PW)'(pwx) + (psd_pkg::PW)'(pwy);
			it_s1 <= in_item;
			dx_s1 <= dx;
			dy_s1 <= dy;
		end
	end

	always_comb begin
		job_valid = v1_s1;
		job.num = dd_s1;
		job.den = l2_s1;
		job.qx = it_s1.query_x;
		job.qy = it_s1.query_y;
		job.sx = it_s1.start_x;
		job.sy = it_s1.start_y;
		job.dx = dx_s1;
		job.dy = dy_s1;
		if (dd_s1 <= 0)          job.sel = psd_pkg::SEL_START;
		else if (dd_s1 >= l2_s1) job.sel = psd_pkg::SEL_END;
		else                     job.sel = psd_pkg::SEL_FRAC;
	end
endmodule

FILE: hdl/psd_queue.sv
// Short queue between front and back end.
// Depends on psd_pkg.
module psd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  psd_pkg::job_t wdata,
	output logic          almost_full,
	input  logic          rd,
	output logic          not_empty,
	output psd_pkg::job_t rdata
);
	psd_pkg::job_t mem_q [psd_pkg::QDEPTH];
	logic [psd_pkg::QAW-1:0] wp_q, rp_q;
	logic [psd_pkg::QAW:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (psd_pkg::QAW+1)'(wr) - (psd_pkg::QAW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	assign rdata = mem_q[rp_q];
	assign not_empty = cnt_q != '0;
	// one in front stage plus one arriving
	assign almost_full = cnt_q >= (psd_pkg::QAW+1)'(psd_pkg::QDEPTH - 2);
endmodule

FILE: hdl/psd_back.sv
// Back end: pipelined fraction divider, scaling, distance, output register.
// Depends on psd_pkg.
module psd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  psd_pkg::job_t      job,
	output logic               job_take,
	output logic               empty,
	input  logic               pop,
	output psd_pkg::out_item_t res
);
	localparam int N = psd_pkg::FB;
	localparam int CW = psd_pkg::CW;
	localparam int PW = psd_pkg::PW;

	psd_pkg::pipe_ctl_t ctl;
	logic [N:0] v_q;
	psd_pkg::job_t j_q [N+1];
	logic [PW-1:0] r_q [N+1];
	logic [N-1:0] p_q [N+1];
	logic advance;
	logic ov_s1, ov_s2, ov_s3;
	logic signed [CW:0] sx_s1, sy_s1, qx_s1, qy_s1, ex_s1, ey_s1;
	logic signed [CW+N+1:0] mx_s1, my_s1;
	logic [1:0] sel_s1;
	logic signed [CW:0] px_s2, py_s2, ux, uy;
	logic signed [CW:0] qx_s2, qy_s2;
	logic signed [PW-1:0] ux2, uy2;
	logic [psd_pkg::DW-1:0] sqx_s3, sqy_s3;
	logic signed [CW-1:0] px_s3, py_s3;
	psd_pkg::out_item_t out_q;
	logic out_v_q;
	logic signed [CW+N+1:0] tx, ty;

	assign advance = !out_v_q || pop;
	assign ctl.valid = ov_s3;
	assign ctl.stall = !advance;
	assign job_take = job_valid && !ctl.stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			ov_s1 <= 1'b0;
			ov_s2 <= 1'b0;
			ov_s3 <= 1'b0;
			out_v_q <= 1'b0;
		end else if (advance) begin
			v_q <= {v_q[N-1:0], job_valid};
			ov_s1 <= v_q[N];
			ov_s2 <= ov_s1;
			ov_s3 <= ov_s2;
			out_v_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			j_q[0] <= job;
			r_q[0] <= job.num;
			p_q[0] <= '0;
			for (int i = 0; i < N; i++) begin
				j_q[i+1] <= j_q[i];
				if (r_q[i] >= j_q[i].den - r_q[i]) begin
					r_q[i+1] <= r_q[i] - (j_q[i].den - r_q[i]);
					p_q[i+1] <= {p_q[i][N-2:0], 1'b1};
				end else begin
					r_q[i+1] <= r_q[i] + r_q[i];
					p_q[i+1] <= {p_q[i][N-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sel_s1 <= j_q[N].sel;
			sx_s1 <= {j_q[N].sx[CW-1], j_q[N].sx};
			sy_s1 <= {j_q[N].sy[CW-1], j_q[N].sy};
			qx_s1 <= {j_q[N].qx[CW-1], j_q[N].qx};
			qy_s1 <= {j_q[N].qy[CW-1], j_q[N].qy};
			ex_s1 <= {j_q[N].sx[CW-1], j_q[N].sx} + j_q[N].dx;
			ey_s1 <= {j_q[N].sy[CW-1], j_q[N].sy} + j_q[N].dy;
			mx_s1 <= $signed({2'b00, p_q[N]}) * j_q[N].dx;
			my_s1 <= $signed({2'b00, p_q[N]}) * j_q[N].dy;
		end
	end

	always_comb begin
		tx = mx_s1 + (CW+N+2)'(1 << (N-1));
		ty = my_s1 + (CW+N+2)'(1 << (N-1));
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			qx_s2 <= qx_s1;
			qy_s2 <= qy_s1;
			case (sel_s1)
				psd_pkg::SEL_START: begin
					px_s2 <= sx_s1;
					py_s2 <= sy_s1;
				end
				psd_pkg::SEL_END: begin
					px_s2 <= ex_s1;
					py_s2 <= ey_s1;
				end
				default: begin
					px_s2 <= sx_s1 + (CW+1)'(tx >>> N);
					py_s2 <= sy_s1 + (CW+1)'(ty >>> N);
				end
			endcase
		end
	end

	always_comb begin
		ux = qx_s2 - px_s2;
		uy = qy_s2 - py_s2;
		ux2 = ux * ux;
		uy2 = uy * uy;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sqx_s3 <= psd_pkg::DW'(ux2);
			sqy_s3 <= psd_pkg::DW'(uy2);
			px_s3 <= px_s2[CW-1:0];
			py_s3 <= py_s2[CW-1:0];
			out_q.dist_sq <= sqx_s3 + sqy_s3;
			out_q.proj_x <= px_s3;
			out_q.proj_y <= py_s3;
		end
	end

	assign empty = !out_v_q;
	assign res = out_q;
endmodule

FILE: hdl/point_segment_distance_sq.sv
// Top level of the point to segment distance block.
// Depends on psd_pkg, psd_front, psd_queue, psd_back and the macro header.
//
// Input channel: push/full with one in_item_t request (query, start, end).
// Output channel: empty/pop with one out_item_t (dist_sq, proj_x, proj_y).
// Each request yields exactly one result, in order.
// Throughput: one request per cycle while results are popped.
// A request passes the front register, the queue, the pipelined restoring
// divider (one quotient bit per stage) and the back end's output stages.
// A short queue parts the front end from the back end; when pop stays low
// the back end holds, the queue fills and full rises.
// Reset clears the valid flags and the queue pointers and count.
`include "point_segment_distance_sq_macros.svh"
module point_segment_distance_sq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  psd_pkg::in_item_t  in_item,
	output logic               empty,
	input  logic               pop,
	output psd_pkg::out_item_t out_item
);
	logic job_valid, q_ne, q_afull, take;
	psd_pkg::job_t job, q_job;

	assign full = q_afull;

	psd_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(push && !full), .in_item(in_item),
		.stall(1'b0), .job_valid(job_valid), .job(job)
	);

	psd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(job_valid), .wdata(job),
		.almost_full(q_afull), .rd(take), .not_empty(q_ne), .rdata(q_job)
	);

	psd_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(q_ne), .job(q_job),
		.job_take(take), .empty(empty), .pop(pop), .res(out_item)
	);

	`PSD_ASSERT_IMP(a_take_needs_data, clk, arst_n, take, q_ne, "take from empty queue")
	`PSD_ASSERT_NXT(a_hold_result, clk, arst_n, !empty && !pop, !empty && $stable(out_item), "result dropped")
	`PSD_ASSERT_IMP(a_no_overflow, clk, arst_n, job_valid && !take, !(u_queue.cnt_q == 3'd4), "queue overflow")
endmodule
